// ===== hw/rtl/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CHANGE = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FIRED     = 3'd3;
  localparam logic [2:0] ST_NONE_DUE  = 3'd4;

  // Operations on the sorted cell row
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  localparam logic [62:0] TIME_MAX = {63{1'b1}};

  // At most this many pops per tick; also the result buffer depth
  localparam int MAX_RESULTS = 16;
  localparam int RES_AW      = $clog2(MAX_RESULTS);
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  event_id;
    logic [62:0] event_time;
    logic [62:0] now;
  } stq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fired_id;
    logic [62:0] fired_time;
    logic [62:0] head_time;
    logic        last;
  } stq_out_t;

  // One buffered result, before head time and last mark are attached
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fired_id;
    logic [62:0] fired_time;
  } stq_ent_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  id;
    logic [62:0] t;
  } cell_req_t;

  typedef struct packed {
    logic        found;
    logic        full;
    logic        empty;
    logic [7:0]  head_id;
    logic [62:0] head_time;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_front.sv =====
`default_nettype none

// Two-entry command queue in front of the sequencer
module stq_front
  import stq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  stq_in_t wr_data,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output stq_in_t rd_data
);

  stq_in_t    mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stq_cells.sv =====
`default_nettype none

// Row of sorted cells, slot 0 earliest; insert, remove and pop each work
// through parallel compare and shift.
module stq_cells
  import stq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic       clk,
  input  logic       rst,
  input  cell_req_t  req,
  output cell_stat_t stat
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [62:0]   due_time [DEPTH];
  logic [7:0]    ev_id    [DEPTH];
  logic [CW-1:0] occ;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] le;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] hit_upto;
  logic [DEPTH-1:0] dn_le;
  logic [62:0]      dn_t [DEPTH];
  logic [7:0]       dn_id [DEPTH];
  logic [62:0]      up_t [DEPTH];
  logic [7:0]       up_id [DEPTH];

  assign stat.found     = |match;
  assign stat.full      = (occ == CW'(DEPTH));
  assign stat.empty     = (occ == '0);
  assign stat.head_id   = ev_id[0];
  assign stat.head_time = due_time[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i]    = (occ > CW'(i));
    assign le[i]       = valid[i] && (due_time[i] <= req.t);
    assign match[i]    = valid[i] && (ev_id[i] == req.id);
    assign hit_upto[i] = |match[i:0];

    // Neighbour below: the new entry lands where the prefix of "stay" ends
    if (i == 0) begin : g_first
      assign dn_le[i] = 1'b1;
      assign dn_t[i]  = req.t;
      assign dn_id[i] = req.id;
    end else begin : g_lower
      assign dn_le[i] = le[i-1];
      assign dn_t[i]  = due_time[i-1];
      assign dn_id[i] = ev_id[i-1];
    end

    // Neighbour above: the top cell keeps its own contents on a shift
    if (i == DEPTH - 1) begin : g_top
      assign up_t[i]  = due_time[i];
      assign up_id[i] = ev_id[i];
    end else begin : g_upper
      assign up_t[i]  = due_time[i+1];
      assign up_id[i] = ev_id[i+1];
    end

    always_ff @(posedge clk) begin
      case (req.op)
        OP_INSERT: begin
          if (!le[i]) begin
            if (dn_le[i]) begin
              due_time[i] <= req.t;
              ev_id[i]    <= req.id;
            end else begin
              due_time[i] <= dn_t[i];
              ev_id[i]    <= dn_id[i];
            end
          end
        end
        OP_REMOVE: begin
          if (hit_upto[i]) begin
            due_time[i] <= up_t[i];
            ev_id[i]    <= up_id[i];
          end
        end
        OP_POP: begin
          due_time[i] <= up_t[i];
          ev_id[i]    <= up_id[i];
        end
        default: ;
      endcase
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      case (req.op)
        OP_INSERT: occ <= occ + CW'(1);
        OP_REMOVE: if (stat.found) occ <= occ - CW'(1);
        OP_POP:    occ <= occ - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stq_results.sv =====
`default_nettype none

// Result buffer: collects one item's results, then shows them once the
// head time after the whole step is known.
module stq_results
  import stq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  stq_ent_t    wr_ent,
  input  logic        publish,
  input  logic [62:0] head_in,
  input  logic        pop,
  output logic        empty,
  output stq_out_t    result,
  output logic        idle
);

  stq_ent_t          mem [MAX_RESULTS];
  logic [RES_AW-1:0] wp;
  logic [RES_AW-1:0] rp;
  logic [RES_CW-1:0] cnt;
  logic              shown;
  logic [62:0]       head_q;
  logic              do_pop;
  stq_ent_t          rd_ent;

  assign empty  = !shown;
  assign idle   = !shown && (cnt == '0);
  assign do_pop = pop && shown;
  assign rd_ent = mem[rp];

  assign result.status     = rd_ent.status;
  assign result.fired_id   = rd_ent.fired_id;
  assign result.fired_time = rd_ent.fired_time;
  assign result.head_time  = head_q;
  assign result.last       = (cnt == RES_CW'(1));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      cnt   <= '0;
      shown <= 1'b0;
    end else begin
      if (wr_en) wp <= wp + RES_AW'(1);
      if (do_pop) rp <= rp + RES_AW'(1);
      cnt <= cnt + RES_CW'(wr_en) - RES_CW'(do_pop);
      if (publish) begin
        shown <= 1'b1;
      end else if (do_pop && (cnt == RES_CW'(1))) begin
        shown <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_ent;
    if (publish) head_q <= head_in;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_timer_event_queue.sv =====
`default_nettype none

// Sorted timer event queue.
// Input channel: push/full with the command transaction on item (add,
// remove, change time, tick). Result channel: empty/pop with one result
// transaction on result; last marks the final result of a command.
// Commands wait in a two-entry queue; a sequencer runs them one at a time
// against a row of DEPTH sorted cells, and results gather in a buffer.
// Add, remove and change each give one result; a tick gives one fired
// result per due event (up to 16) or one result saying none is due.
// A command starts only once the previous command's results are all
// popped, so commands never overlap. A change that finds its entry runs a
// remove step and then an insert step; a tick pops one due event per step
// until none is due or 16 have fired. The compare-and-shift over the cell
// row does each operation in parallel. All results of a command carry the
// head time after the whole command, so results appear together once done.
// Reset empties the queue, the command queue and the result buffer.
// If the receiver stalls, results hold; up to two further commands are
// still taken before full rises.
module sorted_timer_event_queue
  import stq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  stq_in_t  item,
  output logic     empty,
  input  logic     pop,
  output stq_out_t result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_REINS = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  stq_in_t           cur;
  logic [RES_CW-1:0] cnt;
  logic [RES_CW-1:0] cnt_next;

  logic       front_pop;
  logic       front_empty;
  stq_in_t    front_data;
  cell_req_t  creq;
  cell_stat_t cstat;
  logic       wr_en;
  stq_ent_t   wr_ent;
  logic       publish;
  logic       buf_idle;
  logic       due;

  stq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (item),
    .full    (full),
    .pop     (front_pop),
    .empty   (front_empty),
    .rd_data (front_data)
  );

  stq_cells #(.DEPTH(DEPTH)) u_cells (
    .clk  (clk),
    .rst  (rst),
    .req  (creq),
    .stat (cstat)
  );

  stq_results u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_ent  (wr_ent),
    .publish (publish),
    .head_in (cstat.empty ? TIME_MAX : cstat.head_time),
    .pop     (pop),
    .empty   (empty),
    .result  (result),
    .idle    (buf_idle)
  );

  // Head entry is due and the pop limit is not reached
  assign due = !cstat.empty && (cstat.head_time <= cur.now) &&
               (cnt < RES_CW'(MAX_RESULTS));

  // Sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    front_pop  = 1'b0;
    creq.op    = OP_NONE;
    creq.id    = cur.event_id;
    creq.t     = cur.event_time;
    wr_en      = 1'b0;
    wr_ent.status     = ST_OK;
    wr_ent.fired_id   = cur.event_id;
    wr_ent.fired_time = '0;
    publish    = 1'b0;
    case (state)
      S_IDLE: begin
        if (!front_empty && buf_idle) begin
          front_pop  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur.cmd)
          CMD_ADD: begin
            wr_en = 1'b1;
            if (cstat.full) begin
              wr_ent.status = ST_FULL;
            end else begin
              creq.op = OP_INSERT;
            end
            state_next = S_DONE;
          end
          CMD_REMOVE: begin
            creq.op = OP_REMOVE;
            wr_en   = 1'b1;
            if (!cstat.found) wr_ent.status = ST_NOT_FOUND;
            state_next = S_DONE;
          end
          CMD_CHANGE: begin
            creq.op = OP_REMOVE;
            if (cstat.found) begin
              state_next = S_REINS;
            end else begin
              wr_en         = 1'b1;
              wr_ent.status = ST_NOT_FOUND;
              state_next    = S_DONE;
            end
          end
          CMD_TICK: begin
            cnt_next   = '0;
            state_next = S_TICK;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_REINS: begin
        creq.op    = OP_INSERT;
        wr_en      = 1'b1;
        state_next = S_DONE;
      end
      S_TICK: begin
        if (due) begin
          creq.op           = OP_POP;
          wr_en             = 1'b1;
          wr_ent.status     = ST_FIRED;
          wr_ent.fired_id   = cstat.head_id;
          wr_ent.fired_time = cstat.head_time;
          cnt_next          = cnt + RES_CW'(1);
        end else begin
          if (cnt == '0) begin
            wr_en         = 1'b1;
            wr_ent.status = ST_NONE_DUE;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        publish    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Current command
  always_ff @(posedge clk) begin
    if (front_pop) cur <= front_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stq_checker.sv =====
`default_nettype none

// Port-level checks on the result channel
module stq_checker
  import stq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     empty,
  input logic     pop,
  input stq_out_t result
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

  // Only fired results can be followed by more results of the same command
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_FIRED) |-> result.last)
    else $error("non-fired result without last mark");

  // Non-fired results carry a zero fired time
  a_zero_time: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_FIRED) |-> (result.fired_time == '0))
    else $error("non-fired result with nonzero time");

  // A fired event is never later than what remains at the head
  a_fired_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_FIRED) |-> (result.fired_time <= result.head_time))
    else $error("fired time beyond remaining head time");

  // A waiting result holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before pop");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
